// ===== hdl/idm_pkg.sv =====
// Shared constants, codes and helper functions of the metadata deframer.
package idm_pkg;

  localparam int META_BYTES_DEF  = 4096;
  localparam int TITLE_CHARS_DEF = 63;

  localparam int LW = 12;  // block length and byte pointer width
  localparam int IW = 16;  // interval register width

  localparam logic [IW-1:0] INTERVAL_RST = 16'd8192;

  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_TITLE = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  localparam logic [1:0] PH_AUDIO  = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_META   = 2'd2;
  localparam logic [1:0] PH_ERROR  = 2'd3;

  localparam logic [LW-1:0] PREFIX_LEN = 12'd13;
  localparam logic [7:0]    CH_QUOTE   = 8'h27;
  localparam logic [7:0]    CH_SEMI    = 8'h3B;
  localparam logic [7:0]    CH_NUL     = 8'h00;

  // Bytes of StreamTitle='
  function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h53;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h72;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h6D;
      4'd6:    c = 8'h54;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h6C;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h3D;
      4'd12:   c = 8'h27;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

// ===== hdl/idm_in_if.sv =====
// Stream byte request channel.
interface idm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

// ===== hdl/idm_out_if.sv =====
// Result request channel.
interface idm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== hdl/icy_metadata_deframer_unit.sv =====
// Top level of the metadata deframer: stream demux, block store and title scanner.
//
//  channel  | dir | payload                          | handshake
//  in_if    | in  | stream_byte[7:0]                 | valid/ready
//  out_if   | out | kind[1:0], value[7:0], last      | valid/ready
//  cfg      | in  | cfg_wdata[15:0] (interval)       | cfg_we, no wait
//
// Audio, length and metadata bytes are accepted only when the output slot
// is free. The last metadata byte starts the title scan: one shared memory read
// port walks the block, with a request state and a use state for each byte read.
// No request is taken during the scan. Reset is synchronous, active low, and
// clears the control state; the block store holds no reset value.
// A stalled result holds in the output register while out_if.ready is low.
module icy_metadata_deframer_unit import idm_pkg::*; #(
  parameter int META_BYTES  = META_BYTES_DEF,
  parameter int TITLE_CHARS = TITLE_CHARS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  idm_in_if.sink        in_if,
  idm_out_if.source     out_if,
  input  logic          cfg_we,
  input  logic [IW-1:0] cfg_wdata
);

  localparam int AW = $clog2(META_BYTES);
  localparam int KW = $clog2(TITLE_CHARS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_REQ = 4'd1;
  localparam logic [3:0] S_SCAN_USE = 4'd2;
  localparam logic [3:0] S_EVAL     = 4'd3;
  localparam logic [3:0] S_LS_REQ   = 4'd4;
  localparam logic [3:0] S_LS_USE   = 4'd5;
  localparam logic [3:0] S_TS_REQ   = 4'd6;
  localparam logic [3:0] S_TS_USE   = 4'd7;
  localparam logic [3:0] S_LEN      = 4'd8;
  localparam logic [3:0] S_E_REQ    = 4'd9;
  localparam logic [3:0] S_E_USE    = 4'd10;
  localparam logic [3:0] S_NONE     = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [IW-1:0] interval_r;
  logic [IW-1:0] audio_cnt_r, audio_cnt_nxt;
  logic [LW-1:0] meta_rem_r, meta_rem_nxt;
  logic [LW-1:0] meta_len_r, meta_len_nxt;

  // scanner registers
  logic [LW-1:0] ptr_r, ptr_nxt;        // scan pointer, then text length
  logic          pfx_ok_r, pfx_ok_nxt;
  logic          found_r, found_nxt;
  logic [LW-1:0] fq_r, fq_nxt;          // quote of first closing pair
  logic          hlq_r, hlq_nxt;
  logic [LW-1:0] lq_r, lq_nxt;          // last quote
  logic          prevq_r, prevq_nxt;
  logic [LW-1:0] start_r, start_nxt;
  logic [LW-1:0] end_r, end_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] tlen_r, tlen_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_value_r, out_value_nxt;
  logic          out_last_r, out_last_nxt;

  logic [7:0]    mem [META_BYTES];
  logic [7:0]    rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic          out_free, in_fire;
  logic [7:0]    b;
  logic [IW-1:0] cnt_inc;
  logic [LW-1:0] idx, rem_dec, tlen_full;

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && out_free;
  assign in_fire     = in_if.valid && in_if.ready;
  assign b           = in_if.stream_byte;
  assign cnt_inc     = audio_cnt_r + 16'd1;
  assign idx         = meta_len_r - meta_rem_r;
  assign rem_dec     = (meta_rem_r != '0) ? meta_rem_r - 12'd1 : meta_rem_r;
  assign tlen_full   = end_r - start_r;

  assign out_if.valid = out_valid_r;
  assign out_if.kind  = out_kind_r;
  assign out_if.value = out_value_r;
  assign out_if.last  = out_last_r;

  // Store metadata bytes; read at most one byte per request state.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= b;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    audio_cnt_nxt = audio_cnt_r;
    meta_rem_nxt  = meta_rem_r;
    meta_len_nxt  = meta_len_r;
    ptr_nxt       = ptr_r;
    pfx_ok_nxt    = pfx_ok_r;
    found_nxt     = found_r;
    fq_nxt        = fq_r;
    hlq_nxt       = hlq_r;
    lq_nxt        = lq_r;
    prevq_nxt     = prevq_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    k_nxt         = k_r;
    tlen_nxt      = tlen_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = AW'(idx);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (phase_r == PH_ERROR) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ERR;
            out_value_nxt = '0;
            out_last_nxt  = 1'b1;
          end else if (interval_r == '0) begin
            // zero interval: pass everything, drop any partial block
            phase_nxt     = PH_AUDIO;
            audio_cnt_nxt = '0;
            meta_rem_nxt  = '0;
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_AUDIO;
            out_value_nxt = b;
            out_last_nxt  = 1'b1;
          end else begin
            unique case (phase_r)
              PH_AUDIO: begin
                if (cnt_inc >= interval_r || cnt_inc == '0) begin
                  audio_cnt_nxt = '0;
                  phase_nxt     = PH_LENGTH;
                end else begin
                  audio_cnt_nxt = cnt_inc;
                end
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_AUDIO;
                out_value_nxt = b;
                out_last_nxt  = 1'b1;
              end
              PH_LENGTH: begin
                if (b == 8'd0) begin
                  phase_nxt = PH_AUDIO;
                end else if (b[7]) begin
                  phase_nxt     = PH_ERROR;
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = KIND_ERR;
                  out_value_nxt = '0;
                  out_last_nxt  = 1'b1;
                end else begin
                  meta_len_nxt = {1'b0, b[6:0], 4'b0000};
                  meta_rem_nxt = {1'b0, b[6:0], 4'b0000};
                  phase_nxt    = PH_META;
                end
              end
              default: begin
                wr_en        = 1'b1;
                meta_rem_nxt = rem_dec;
                if (rem_dec == '0) begin
                  // last byte of the block: start the title scan
                  phase_nxt     = PH_AUDIO;
                  audio_cnt_nxt = '0;
                  ptr_nxt       = '0;
                  pfx_ok_nxt    = 1'b1;
                  found_nxt     = 1'b0;
                  hlq_nxt       = 1'b0;
                  prevq_nxt     = 1'b0;
                  state_nxt     = S_SCAN_REQ;
                end
              end
            endcase
          end
        end
      end

      S_SCAN_REQ: begin
        if (ptr_r == meta_len_r) begin
          state_nxt = S_EVAL;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(ptr_r);
          state_nxt = S_SCAN_USE;
        end
      end

      S_SCAN_USE: begin
        if (rdata_r == CH_NUL) begin
          state_nxt = S_EVAL;
        end else begin
          if (ptr_r < PREFIX_LEN && rdata_r != prefix_byte(ptr_r[3:0])) begin
            pfx_ok_nxt = 1'b0;
          end
          if (ptr_r >= PREFIX_LEN && rdata_r == CH_QUOTE) begin
            hlq_nxt = 1'b1;
            lq_nxt  = ptr_r;
          end
          if (ptr_r > PREFIX_LEN && prevq_r && rdata_r == CH_SEMI && !found_r) begin
            found_nxt = 1'b1;
            fq_nxt    = ptr_r - 12'd1;
          end
          prevq_nxt = (rdata_r == CH_QUOTE);
          ptr_nxt   = ptr_r + 12'd1;
          state_nxt = S_SCAN_REQ;
        end
      end

      S_EVAL: begin
        if (ptr_r < PREFIX_LEN || !pfx_ok_r) begin
          state_nxt = S_NONE;
        end else begin
          start_nxt = PREFIX_LEN;
          end_nxt   = found_r ? fq_r : (hlq_r ? lq_r : ptr_r);
          state_nxt = S_LS_REQ;
        end
      end

      S_LS_REQ: begin
        if (start_r < end_r) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(start_r);
          state_nxt = S_LS_USE;
        end else begin
          state_nxt = S_TS_REQ;
        end
      end

      S_LS_USE: begin
        if (is_space(rdata_r)) begin
          start_nxt = start_r + 12'd1;
          state_nxt = S_LS_REQ;
        end else begin
          state_nxt = S_TS_REQ;
        end
      end

      S_TS_REQ: begin
        if (end_r > start_r) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(end_r - 12'd1);
          state_nxt = S_TS_USE;
        end else begin
          state_nxt = S_LEN;
        end
      end

      S_TS_USE: begin
        if (is_space(rdata_r)) begin
          end_nxt   = end_r - 12'd1;
          state_nxt = S_TS_REQ;
        end else begin
          state_nxt = S_LEN;
        end
      end

      S_LEN: begin
        if (tlen_full == '0) begin
          state_nxt = S_NONE;
        end else begin
          tlen_nxt  = (tlen_full > LW'(TITLE_CHARS)) ? KW'(TITLE_CHARS) : KW'(tlen_full);
          k_nxt     = '0;
          state_nxt = S_E_REQ;
        end
      end

      S_E_REQ: begin
        rd_en     = 1'b1;
        rd_addr   = AW'(start_r + LW'(k_r));
        state_nxt = S_E_USE;
      end

      S_E_USE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_TITLE;
          out_value_nxt = rdata_r;
          out_last_nxt  = (k_r + KW'(1) == tlen_r);
          if (k_r + KW'(1) == tlen_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = S_E_REQ;
          end
        end
      end

      S_NONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_NONE;
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_AUDIO;
      interval_r  <= INTERVAL_RST;
      audio_cnt_r <= '0;
      meta_rem_r  <= '0;
      meta_len_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      audio_cnt_r <= audio_cnt_nxt;
      meta_rem_r  <= meta_rem_nxt;
      meta_len_r  <= meta_len_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        interval_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pfx_ok_r    <= pfx_ok_nxt;
    found_r     <= found_nxt;
    fq_r        <= fq_nxt;
    hlq_r       <= hlq_nxt;
    lq_r        <= lq_nxt;
    prevq_r     <= prevq_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    k_r         <= k_nxt;
    tlen_r      <= tlen_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ===== hdl/idm_checker.sv =====
// Port-level checker of the metadata deframer and its bind.
module idm_checker import idm_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_value,
  input logic       out_last
);

  logic out_fire;
  logic err_seen_r;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_fire && out_kind == KIND_ERR) begin
      err_seen_r <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value))
    else $error("stalled result changed");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TITLE |-> out_last)
    else $error("single result without last");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_NONE || out_kind == KIND_ERR) |-> out_value == 8'd0)
    else $error("marker with nonzero value");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && err_seen_r |-> out_kind == KIND_ERR)
    else $error("error state left");

endmodule

bind icy_metadata_deframer_unit idm_checker u_idm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_kind  (out_if.kind),
  .out_value (out_if.value),
  .out_last  (out_if.last)
);
